@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/mnt_esc_pkg.sv @@
// Types, character codes and helper functions of the mount unit name escaper.
package mnt_esc_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_path;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } out_item_t;

    localparam int NUM_STEPS = 13;

    typedef logic [3:0]           step_t;
    typedef logic [NUM_STEPS-1:0] step_mask_t;

    // Output steps of one job, in emission order.
    localparam step_t STEP_DASH  = 4'd0;
    localparam step_t STEP_CHAR  = 4'd1;
    localparam step_t STEP_BSL   = 4'd2;
    localparam step_t STEP_X     = 4'd3;
    localparam step_t STEP_HI    = 4'd4;
    localparam step_t STEP_LO    = 4'd5;
    localparam step_t STEP_SDASH = 4'd6;
    localparam step_t STEP_SFX0  = 4'd7;
    localparam step_t STEP_SFX1  = 4'd8;
    localparam step_t STEP_SFX2  = 4'd9;
    localparam step_t STEP_SFX3  = 4'd10;
    localparam step_t STEP_SFX4  = 4'd11;
    localparam step_t STEP_SFX5  = 4'd12;

    // A job: which output steps to run, and the byte that they refer to.
    typedef struct packed {
        step_mask_t steps;
        logic [7:0] ch;
    } job_t;

    localparam logic [7:0] CHAR_SLASH      = 8'h2f;
    localparam logic [7:0] CHAR_DOT        = 8'h2e;
    localparam logic [7:0] CHAR_DASH       = 8'h2d;
    localparam logic [7:0] CHAR_BACKSLASH  = 8'h5c;
    localparam logic [7:0] CHAR_X          = 8'h78;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CHAR_M          = 8'h6d;
    localparam logic [7:0] CHAR_O          = 8'h6f;
    localparam logic [7:0] CHAR_U          = 8'h75;
    localparam logic [7:0] CHAR_N          = 8'h6e;
    localparam logic [7:0] CHAR_T          = 8'h74;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] HEX_ALPHA_BASE  = 8'h57;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v <= 4'd9) ? (CHAR_ZERO + {4'd0, v}) : (HEX_ALPHA_BASE + {4'd0, v});
    endfunction

    function automatic logic passes(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
    endfunction

endpackage

@@ design/mnt_esc_front.sv @@
// Front end: tracks slash state per path and turns each request that yields output into a job.
module mnt_esc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  mnt_esc_pkg::in_item_t item,
    output logic                  push,
    output mnt_esc_pkg::job_t     job
);
    import mnt_esc_pkg::*;

    logic prev_slash_reg, prev_slash_next;
    logic dash_pend_reg, dash_pend_next;
    logic at_first_reg, at_first_next;
    logic only_slash_reg, only_slash_next;
    logic is_slash;
    logic pass_char;

    assign is_slash  = (item.char_in == CHAR_SLASH);
    assign pass_char = ((item.char_in == CHAR_DOT) && !at_first_reg) || passes(item.char_in);

    always_comb begin
        prev_slash_next = prev_slash_reg;
        dash_pend_next  = dash_pend_reg;
        at_first_next   = at_first_reg;
        only_slash_next = only_slash_reg;
        job.steps       = '0;
        job.ch          = item.char_in;

        if (is_slash) begin
            if (!prev_slash_reg) begin
                if (at_first_reg) begin
                    at_first_next = 1'b0;
                end else begin
                    dash_pend_next = 1'b1;
                end
            end
            prev_slash_next = 1'b1;
        end else begin
            job.steps[STEP_DASH] = dash_pend_reg;
            if (pass_char) begin
                job.steps[STEP_CHAR] = 1'b1;
            end else begin
                job.steps[STEP_BSL] = 1'b1;
                job.steps[STEP_X]   = 1'b1;
                job.steps[STEP_HI]  = 1'b1;
                job.steps[STEP_LO]  = 1'b1;
            end
            dash_pend_next  = 1'b0;
            at_first_next   = 1'b0;
            only_slash_next = 1'b0;
            prev_slash_next = 1'b0;
        end

        if (item.end_of_path) begin
            // When the final byte is a slash, a pending dash came from a trailing slash and is dropped.
            job.steps[STEP_SDASH] = only_slash_reg && is_slash;
            job.steps[STEP_SFX0]  = 1'b1;
            job.steps[STEP_SFX1]  = 1'b1;
            job.steps[STEP_SFX2]  = 1'b1;
            job.steps[STEP_SFX3]  = 1'b1;
            job.steps[STEP_SFX4]  = 1'b1;
            job.steps[STEP_SFX5]  = 1'b1;
            prev_slash_next = 1'b0;
            dash_pend_next  = 1'b0;
            at_first_next   = 1'b1;
            only_slash_next = 1'b1;
        end
    end

    assign push = accept && (!is_slash || item.end_of_path);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_slash_reg <= 1'b0;
            dash_pend_reg  <= 1'b0;
            at_first_reg   <= 1'b1;
            only_slash_reg <= 1'b1;
        end else if (accept) begin
            prev_slash_reg <= prev_slash_next;
            dash_pend_reg  <= dash_pend_next;
            at_first_reg   <= at_first_next;
            only_slash_reg <= only_slash_next;
        end
    end

endmodule

@@ design/mnt_esc_queue.sv @@
// Short job queue between the front end and the back end.
module mnt_esc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  mnt_esc_pkg::job_t                   push_job,
    input  logic                                pop,
    output mnt_esc_pkg::job_t                   head_job,
    output logic                                full,
    output logic [$clog2(DEPTH+1)-1:0]          count
);
    import mnt_esc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count    = count_reg;
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/mnt_esc_back.sv @@
// Back end: walks the steps of each job and drives one output byte per cycle while m_ready does not stall it.
module mnt_esc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_nonempty,
    input  mnt_esc_pkg::job_t      head_job,
    output logic                   pop,
    output logic                   busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mnt_esc_pkg::out_item_t m_data
);
    import mnt_esc_pkg::*;

    job_t      job_reg;
    step_t     step_reg;
    logic      have_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic      out_free;
    logic      emit;
    logic      nxt_found;
    step_t     nxt_step;
    logic      first_found;
    step_t     first_step;
    logic      finishing;
    logic [7:0] step_byte;

    // Lowest present step above the given one, or the lowest at all.
    function automatic logic [4:0] next_in_mask(input step_mask_t mask, input step_t cur,
                                                 input logic from_start);
        logic  found;
        step_t pick;
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (!found && mask[i] && (from_start || (step_t'(i) > cur))) begin
                found = 1'b1;
                pick  = step_t'(i);
            end
        end
        return {found, pick};
    endfunction

    assign {nxt_found, nxt_step}     = next_in_mask(job_reg.steps, step_reg, 1'b0);
    assign {first_found, first_step} = next_in_mask(head_job.steps, STEP_DASH, 1'b1);

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = have_reg && out_free;
    assign finishing = emit && !nxt_found;
    assign pop       = q_nonempty && first_found && (!have_reg || finishing);

    always_comb begin
        case (step_reg)
            STEP_DASH:  step_byte = CHAR_DASH;
            STEP_CHAR:  step_byte = job_reg.ch;
            STEP_BSL:   step_byte = CHAR_BACKSLASH;
            STEP_X:     step_byte = CHAR_X;
            STEP_HI:    step_byte = hex_digit(job_reg.ch[7:4]);
            STEP_LO:    step_byte = hex_digit(job_reg.ch[3:0]);
            STEP_SDASH: step_byte = CHAR_DASH;
            STEP_SFX0:  step_byte = CHAR_DOT;
            STEP_SFX1:  step_byte = CHAR_M;
            STEP_SFX2:  step_byte = CHAR_O;
            STEP_SFX3:  step_byte = CHAR_U;
            STEP_SFX4:  step_byte = CHAR_N;
            STEP_SFX5:  step_byte = CHAR_T;
            default:    step_byte = CHAR_DASH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                have_reg <= 1'b1;
            end else if (finishing) begin
                have_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg  <= head_job;
            step_reg <= first_step;
        end else if (emit && nxt_found) begin
            step_reg <= nxt_step;
        end
        if (emit) begin
            m_data_reg.char_out <= step_byte;
            m_data_reg.last_out <= (step_reg == STEP_SFX5);
        end
    end

    assign busy    = have_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/mount_unit_name_escaper.sv @@
// Top level of the mount unit name escaper: front end, job queue and back end.
//
//   Channel   Direction  Signals                     Carries
//   s_        in         s_valid, s_ready, s_data    one path byte and its end flag
//   m_        out        m_valid, m_ready, m_data    one unit name byte and its last flag
//
// A request makes a job of one to eleven output bytes, unless it is a slash that
// is not the final byte, which makes no job and costs no back end time.
// The back end emits one byte per cycle while m_ready does not stall it: one for a plain
// byte, four for an escaped one and up to eleven for a job with the suffix.
// Reset is synchronous and active low; it clears the path state, queue and output valid flag.
// A stalled m_ready holds the output byte and fills the queue, after which s_ready falls.
module mount_unit_name_escaper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mnt_esc_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mnt_esc_pkg::out_item_t m_data
);
    import mnt_esc_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             s_accept;
    logic             push;
    job_t             push_job;
    logic             pop;
    job_t             head_job;
    logic             q_full;
    logic [CNT_W-1:0] q_count;
    logic             back_busy;

    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    // The front end classifies each request and updates the per-path state.
    mnt_esc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .item    (s_data),
        .push    (push),
        .job     (push_job)
    );

    // The queue lets the front end run ahead while the back end expands a job.
    mnt_esc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .count    (q_count)
    );

    // The back end turns each job into bytes through the output register.
    mnt_esc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_count != '0),
        .head_job   (head_job),
        .pop        (pop),
        .busy       (back_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // The closing byte of every unit name is the 't' of the suffix.
    `ASSERT_SAME(a_last_is_t, aclk, aresetn, m_valid && m_data.last_out, m_data.char_out == CHAR_T)
    // A request that yields output always leaves a job waiting in the queue.
    `ASSERT_NEXT(a_job_queued, aclk, aresetn, s_accept && (s_data.char_in != CHAR_SLASH), q_count != '0)
    // While a job waits in the queue, the back end is always busy in the next cycle.
    `ASSERT_NEXT(a_back_pulls, aclk, aresetn, q_count != '0, back_busy)

endmodule
